[hdl/rtss_pkg.sv]
// ----------------------------------------------------------------------------
// rtss_pkg
// Shared types, codes and the sort-key compare for the record table sorter.
// ----------------------------------------------------------------------------
package rtss_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  typedef struct packed {
    logic signed [31:0] id;
    logic [7:0]         category;
    logic [31:0]        price;
    logic [15:0]        shelf;
    logic [23:0]        quantity;
  } rec_t;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_DUMP   = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_UPDATE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [2:0] KEY_ID       = 3'd0;
  localparam logic [2:0] KEY_CATEGORY = 3'd1;
  localparam logic [2:0] KEY_PRICE    = 3'd2;
  localparam logic [2:0] KEY_SHELF    = 3'd3;
  localparam logic [2:0] KEY_QTY_UP   = 3'd4;
  localparam logic [2:0] KEY_QTY_DOWN = 3'd5;

  typedef struct packed {
    logic       sort_en;
    logic       phase;
    logic [2:0] key;
  } sort_ctrl_t;

  typedef struct packed {
    logic en;
    rec_t rec;
  } cell_wr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_EMPTY, S_SORT, S_DUMP_RD, S_DUMP_OUT,
    S_SR_CHK, S_SR_LO, S_SR_HI, S_SR_MUL, S_SR_DIVGO, S_SR_DIV,
    S_SR_PROBE, S_SR_CMP, S_SR_MISS, S_SR_HIT
  } state_e;

  // true when a must move strictly ahead of b
  function automatic logic goes_before(input rec_t a, input rec_t b, input logic [2:0] key);
    logic r;
    unique case (key)
      KEY_ID:       r = $signed(a.id) < $signed(b.id);
      KEY_CATEGORY: r = a.category < b.category;
      KEY_PRICE:    r = a.price < b.price;
      KEY_SHELF:    r = a.shelf < b.shelf;
      KEY_QTY_UP:   r = a.quantity < b.quantity;
      KEY_QTY_DOWN: r = a.quantity > b.quantity;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[hdl/rtss_cell.sv]
// ----------------------------------------------------------------------------
// rtss_cell
// One table slot. Holds a record, compares with its right neighbor and swaps
// on odd/even transposition phases.
// ----------------------------------------------------------------------------
module rtss_cell import rtss_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int IDX         = 0,
  localparam int IDXW       = $clog2(TABLE_DEPTH),
  localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  sort_ctrl_t       ctrl_i,
  input  logic [CW-1:0]    count_i,
  input  logic [IDXW-1:0]  wr_idx_i,
  input  cell_wr_t         wr_i,
  input  rec_t             left_rec_i,
  input  logic             left_swap_i,
  input  rec_t             right_rec_i,
  output rec_t             rec_o,
  output logic             swap_o
);

  localparam logic PAR = (IDX % 2) == 1;

  rec_t rec_q, rec_d;

  assign swap_o = ctrl_i.sort_en && (ctrl_i.phase == PAR) && (CW'(IDX + 1) < count_i)
                  && goes_before(right_rec_i, rec_q, ctrl_i.key);

  always_comb begin
    rec_d = rec_q;
    if (wr_i.en && (wr_idx_i == IDXW'(IDX))) begin
      rec_d = wr_i.rec;
    end else if (swap_o) begin
      rec_d = right_rec_i;
    end else if (left_swap_i) begin
      rec_d = left_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

[hdl/rtss_div.sv]
// ----------------------------------------------------------------------------
// rtss_div
// Restoring divider, one quotient bit per cycle, for the interpolation probe.
// ----------------------------------------------------------------------------
module rtss_div import rtss_pkg::*; #(
  parameter int QW  = 4,
  parameter int DW  = 33,
  localparam int NW = DW + QW,
  localparam int CNW = $clog2(QW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  logic           busy_q;
  logic           done_q;
  logic [CNW-1:0] cnt_q;
  logic [NW-1:0]  rem_q;
  logic [NW-1:0]  dsh_q;
  logic [QW-1:0]  quo_q;
  logic           ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(QW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= NW'(den_i) << (QW - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= (quo_q << 1) | QW'(ge);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hdl/record_table_sort_and_search_top.sv]
// ----------------------------------------------------------------------------
// record_table_sort_and_search_top
// Record table with stable sort on a chain of cells, dump and interpolation
// search by id with optional update.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser           tlast
// s_axis   in   id,category,price,shelf,quantity        mode,sort_key   -
// m_axis   out  slot,id,category,price,shelf,quantity   status          last
//
// Append, full and empty: output register loaded from the append or empty state once the output is free.
// Sort: TABLE_DEPTH odd/even transposition passes, one per cycle, in the cells.
// Dump: each record is read through the single read port, then sent on the output.
// Search: each probe runs S_SR_CHK to S_SR_CMP, waiting on the serial divider.
// Reset clears the entry count and control; no clearing pass.
// A stalled output beat holds the sequencer; input is taken only when idle.
// ----------------------------------------------------------------------------
module record_table_sort_and_search_top import rtss_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [111:0] s_axis_tdata_i,  // item_id, category, price, shelf, quantity
  input  logic [4:0]   s_axis_tuser_i,  // mode, sort_key
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [119:0] m_axis_tdata_o,  // slot, rec_id, rec_category, rec_price,
                                        // rec_shelf, rec_quantity, zero pad
  output logic [1:0]   m_axis_tuser_o,  // status
  output logic         m_axis_tlast_o
);

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int IW   = IDXW + 2;
  localparam int NUMW = 33 + IDXW;

  state_e state_q, state_d;

  rec_t              item_q;
  logic [1:0]        mode_q;
  logic [2:0]        key_q;
  logic [CW-1:0]     cnt_q;
  logic [IDXW-1:0]   pass_q;
  logic [IDXW-1:0]   idx_q;
  logic signed [IW-1:0] low_q, high_q, d_ext;
  logic signed [31:0] lo_id_q;
  logic [32:0]       kdiff_q, den_q;
  logic [IDXW-1:0]   span_q;
  logic [NUMW-1:0]   num_q;
  logic [IDXW-1:0]   d_q;
  rec_t              rd_q;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [3:0]        out_slot_q;
  rec_t              out_rec_q;
  logic              out_last_q;

  logic              in_acc, out_free, full, in_range;
  logic [IDXW-1:0]   rd_addr;
  logic [IDXW-1:0]   wr_idx;
  cell_wr_t          wr;
  sort_ctrl_t        sctrl;
  logic              out_load;
  logic [1:0]        out_status;
  logic [3:0]        out_slot;
  rec_t              out_rec;
  logic              out_last;
  rec_t              upd_rec;
  logic              div_start, div_done;
  logic [IDXW-1:0]   div_quo;

  rec_t              cell_rec [TABLE_DEPTH];
  logic              cell_swap [TABLE_DEPTH];

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign full     = cnt_q == CW'(TABLE_DEPTH);
  assign in_range = ($signed(item_q.id) >= lo_id_q) && ($signed(item_q.id) <= $signed(rd_q.id));
  assign d_ext    = $signed({2'b00, d_q});

  always_comb begin
    upd_rec          = rd_q;
    upd_rec.price    = item_q.price;
    upd_rec.shelf    = item_q.shelf;
    upd_rec.quantity = item_q.quantity;
  end

  assign sctrl.sort_en = state_q == S_SORT;
  assign sctrl.phase   = pass_q[0];
  assign sctrl.key     = key_q;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rtss_cell #(.TABLE_DEPTH(TABLE_DEPTH), .IDX(i)) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (sctrl),
      .count_i     (cnt_q),
      .wr_idx_i    (wr_idx),
      .wr_i        (wr),
      .left_rec_i  ((i == 0) ? cell_rec[i] : cell_rec[(i == 0) ? 0 : i - 1]),
      .left_swap_i ((i == 0) ? 1'b0 : cell_swap[(i == 0) ? 0 : i - 1]),
      .right_rec_i (cell_rec[(i == TABLE_DEPTH - 1) ? i : i + 1]),
      .rec_o       (cell_rec[i]),
      .swap_o      (cell_swap[i])
    );
  end

  rtss_div #(.QW(IDXW), .DW(33)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i[1:0] == MODE_APPEND) state_d = S_APPEND;
          else if (cnt_q == '0)                   state_d = S_EMPTY;
          else                                    state_d = S_SORT;
        end
      end
      S_APPEND, S_EMPTY, S_SR_MISS, S_SR_HIT: begin
        if (out_free) state_d = S_IDLE;
      end
      S_SORT: begin
        if (pass_q == IDXW'(TABLE_DEPTH - 1)) begin
          state_d = (mode_q == MODE_DUMP) ? S_DUMP_RD : S_SR_CHK;
        end
      end
      S_DUMP_RD: state_d = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (out_free) begin
          state_d = (CW'(idx_q) == cnt_q - CW'(1)) ? S_IDLE : S_DUMP_RD;
        end
      end
      S_SR_CHK:   state_d = (low_q > high_q) ? S_SR_MISS : S_SR_LO;
      S_SR_LO:    state_d = S_SR_HI;
      S_SR_HI: begin
        if (!in_range)                    state_d = S_SR_MISS;
        else if ($signed(rd_q.id) == lo_id_q) state_d = S_SR_PROBE;
        else                              state_d = S_SR_MUL;
      end
      S_SR_MUL:   state_d = S_SR_DIVGO;
      S_SR_DIVGO: state_d = S_SR_DIV;
      S_SR_DIV:   if (div_done) state_d = S_SR_PROBE;
      S_SR_PROBE: state_d = S_SR_CMP;
      S_SR_CMP:   state_d = ($signed(rd_q.id) == $signed(item_q.id)) ? S_SR_HIT : S_SR_CHK;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_addr    = '0;
    wr.en      = 1'b0;
    wr.rec     = item_q;
    wr_idx     = cnt_q[IDXW-1:0];
    out_load   = 1'b0;
    out_status = ST_OK;
    out_slot   = '0;
    out_rec    = '0;
    out_last   = 1'b1;
    div_start  = 1'b0;
    unique case (state_q)
      S_APPEND: begin
        if (out_free) begin
          out_load = 1'b1;
          if (full) begin
            out_status = ST_FULL;
          end else begin
            wr.en    = 1'b1;
            out_rec  = item_q;
            out_slot = 4'(cnt_q[IDXW-1:0]);
          end
        end
      end
      S_EMPTY: begin
        out_load   = out_free;
        out_status = ST_EMPTY;
      end
      S_DUMP_RD: rd_addr = idx_q;
      S_DUMP_OUT: begin
        rd_addr  = idx_q;
        out_load = out_free;
        out_rec  = rd_q;
        out_slot = 4'(idx_q);
        out_last = CW'(idx_q) == cnt_q - CW'(1);
      end
      S_SR_CHK:   rd_addr = low_q[IDXW-1:0];
      S_SR_LO:    rd_addr = high_q[IDXW-1:0];
      S_SR_DIVGO: div_start = 1'b1;
      S_SR_PROBE, S_SR_CMP: rd_addr = d_q;
      S_SR_MISS: begin
        out_load   = out_free;
        out_status = ST_NOTFOUND;
      end
      S_SR_HIT: begin
        rd_addr  = d_q;
        out_load = out_free;
        out_slot = 4'(d_q);
        wr_idx   = d_q;
        wr.rec   = upd_rec;
        if (mode_q == MODE_UPDATE) begin
          out_rec = upd_rec;
          wr.en   = out_free;
        end else begin
          out_rec = rd_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_APPEND && out_free && !full) cnt_q <= cnt_q + CW'(1);
      if (out_load)             out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= cell_rec[rd_addr];
    if (out_load) begin
      out_status_q <= out_status;
      out_slot_q   <= out_slot;
      out_rec_q    <= out_rec;
      out_last_q   <= out_last;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_q <= {s_axis_tdata_i[31:0], s_axis_tdata_i[39:32], s_axis_tdata_i[71:40],
                     s_axis_tdata_i[87:72], s_axis_tdata_i[111:88]};
          mode_q <= s_axis_tuser_i[1:0];
          key_q  <= (s_axis_tuser_i[1:0] == MODE_DUMP) ? s_axis_tuser_i[4:2] : KEY_ID;
          pass_q <= '0;
          idx_q  <= '0;
          low_q  <= '0;
          high_q <= $signed(IW'(cnt_q)) - IW'(1);
        end
      end
      S_SORT:     pass_q <= pass_q + IDXW'(1);
      S_DUMP_OUT: if (out_free) idx_q <= idx_q + IDXW'(1);
      S_SR_LO:    lo_id_q <= $signed(rd_q.id);
      S_SR_HI: begin
        kdiff_q <= {item_q.id[31], item_q.id} - {lo_id_q[31], lo_id_q};
        den_q   <= {rd_q.id[31], rd_q.id} - {lo_id_q[31], lo_id_q};
        span_q  <= IDXW'(high_q - low_q);
        d_q     <= low_q[IDXW-1:0];
      end
      S_SR_MUL:   num_q <= NUMW'(kdiff_q) * NUMW'(span_q);
      S_SR_DIV:   if (div_done) d_q <= low_q[IDXW-1:0] + div_quo;
      S_SR_CMP: begin
        if ($signed(rd_q.id) > $signed(item_q.id))      high_q <= d_ext - IW'(1);
        else if ($signed(rd_q.id) < $signed(item_q.id)) low_q  <= d_ext + IW'(1);
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'b0000, out_rec_q.quantity, out_rec_q.shelf, out_rec_q.price,
                            out_rec_q.category, out_rec_q.id, out_slot_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_cnt_only_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_APPEND) |=> (cnt_q == $past(cnt_q)))
    else $error("entry count moved outside append");

  a_notlast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tuser_o == ST_OK))
    else $error("non-final beat with error status");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_SR_DIV))
    else $error("divider finished outside wait state");

endmodule

[dv/record_table_sort_and_search_top_tb.sv]
// ----------------------------------------------------------------------------
// record_table_sort_and_search_top_tb
// Streams append, sort/dump and id search/update commands into the record
// table. A behavioral table model predicts every output beat. Output beats are
// compared field by field in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module record_table_sort_and_search_top_tb;
  import rtss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LIMIT = 2000000;
  localparam int N_RAND = 320;

  typedef struct {
    logic [1:0] status;
    logic [3:0] slot;
    rec_t       rec;
    logic       last;
  } beat_t;

  typedef struct {
    logic [1:0] mode;
    logic [2:0] key;
    rec_t       rec;
    bit         fixed;
    logic [1:0] fixed_st;
  } cmd_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [4:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  record_table_sort_and_search_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast)
  );

  always #2 clk_i = ~clk_i;

  rec_t        shelf_tbl [DEPTH];
  int unsigned n_rec = 0;
  beat_t       pending_beats [$];
  int          n_err = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;

  function automatic bit moves_ahead(rec_t a, rec_t b, logic [2:0] k);
    case (k)
      KEY_ID:       return $signed(a.id) < $signed(b.id);
      KEY_CATEGORY: return a.category < b.category;
      KEY_PRICE:    return a.price < b.price;
      KEY_SHELF:    return a.shelf < b.shelf;
      KEY_QTY_UP:   return a.quantity < b.quantity;
      KEY_QTY_DOWN: return a.quantity > b.quantity;
      default:      return 1'b0;
    endcase
  endfunction

  task automatic order_table(logic [2:0] k);
    rec_t cur;
    int   j;
    for (int i = 1; i < n_rec; i++) begin
      cur = shelf_tbl[i];
      j = i;
      while (j > 0 && moves_ahead(cur, shelf_tbl[j-1], k)) begin
        shelf_tbl[j] = shelf_tbl[j-1];
        j--;
      end
      shelf_tbl[j] = cur;
    end
  endtask

  function automatic int lookup_id(logic signed [31:0] want);
    int     lo, hi, d;
    longint lo_id, hi_id, num, den;
    lo = 0;
    hi = int'(n_rec) - 1;
    while (lo <= hi && want >= $signed(shelf_tbl[lo].id) &&
           want <= $signed(shelf_tbl[hi].id)) begin
      lo_id = longint'($signed(shelf_tbl[lo].id));
      hi_id = longint'($signed(shelf_tbl[hi].id));
      if (hi_id == lo_id) d = lo;
      else begin
        num = (longint'(want) - lo_id) * longint'(hi - lo);
        den = hi_id - lo_id;
        d = lo + int'(num / den);
      end
      if ($signed(shelf_tbl[d].id) > want) hi = d - 1;
      else if ($signed(shelf_tbl[d].id) < want) lo = d + 1;
      else return d;
    end
    return -1;
  endfunction

  task automatic push_beat(logic [1:0] st, int slot, rec_t r, bit lst);
    beat_t b;
    b.status = st;
    b.slot = slot[3:0];
    b.rec = r;
    b.last = lst;
    pending_beats.push_back(b);
  endtask

  task automatic predict_table(cmd_t c);
    int   d;
    rec_t z;
    z = '0;
    if (c.mode == MODE_APPEND) begin
      if (n_rec >= DEPTH) push_beat(ST_FULL, 0, z, 1'b1);
      else begin
        shelf_tbl[n_rec] = c.rec;
        push_beat(ST_OK, n_rec, c.rec, 1'b1);
        n_rec++;
      end
    end else if (n_rec == 0) begin
      push_beat(ST_EMPTY, 0, z, 1'b1);
    end else if (c.mode == MODE_DUMP) begin
      order_table(c.key);
      for (int j = 0; j < n_rec; j++)
        push_beat(ST_OK, j, shelf_tbl[j], j + 1 == n_rec);
    end else begin
      order_table(KEY_ID);
      d = lookup_id(c.rec.id);
      if (d < 0) push_beat(ST_NOTFOUND, 0, z, 1'b1);
      else begin
        if (c.mode == MODE_UPDATE) begin
          shelf_tbl[d].price = c.rec.price;
          shelf_tbl[d].shelf = c.rec.shelf;
          shelf_tbl[d].quantity = c.rec.quantity;
        end
        push_beat(ST_OK, d, shelf_tbl[d], 1'b1);
      end
    end
    if (c.fixed) pending_beats[pending_beats.size()-1].status = c.fixed_st;
  endtask

  task automatic send_cmd(cmd_t c);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c.rec.quantity, c.rec.shelf, c.rec.price, c.rec.category, c.rec.id};
    s_tuser <= {c.key, c.mode};
    do @(posedge clk_i); while (!s_tready);
    predict_table(c);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    beat_t e;
    rec_t  got;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tdata[35:4], m_tdata[43:36], m_tdata[75:44], m_tdata[91:76],
             m_tdata[115:92]};
      if (pending_beats.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected beat: status %0d slot %0d", m_tuser,
                                  m_tdata[3:0]);
      end else begin
        e = pending_beats.pop_front();
        if (e.status !== m_tuser || e.slot !== m_tdata[3:0] || e.rec !== got ||
            e.last !== m_tlast) begin
          n_err++;
          if (n_err <= 10)
            $display({"mismatch: exp st %0d slot %0d rec %h last %0d",
                      " / got st %0d slot %0d rec %h last %0d"},
                     e.status, e.slot, e.rec, e.last, m_tuser, m_tdata[3:0], got, m_tlast);
        end
      end
    end
  end

  function automatic cmd_t mk(logic [1:0] m, logic [2:0] k, logic [31:0] id, logic [7:0] cat,
                              logic [31:0] pr, logic [15:0] sh, logic [23:0] q,
                              bit fx = 0, logic [1:0] st = ST_OK);
    cmd_t c;
    c.mode = m;
    c.key = k;
    c.rec = {id, cat, pr, sh, q};
    c.fixed = fx;
    c.fixed_st = st;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   sel;
    c = mk(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom, 8'($urandom), $urandom,
           16'($urandom), 24'($urandom));
    sel = $urandom_range(99);
    if (sel < 60 && n_rec > 0) begin
      c.mode = (sel < 40) ? MODE_FIND : MODE_UPDATE;
      c.rec.id = shelf_tbl[$urandom_range(n_rec - 1)].id;
      if ($urandom_range(9) == 0) c.rec.id = c.rec.id + 1;
    end else if (sel < 75) begin
      c.mode = MODE_FIND;
    end else if (sel < 90) begin
      c.mode = MODE_DUMP;
    end else begin
      c.mode = MODE_APPEND;
    end
    return c;
  endfunction

  cmd_t directed [$];

  initial begin
    cmd_t c;
    directed = '{
      mk(MODE_DUMP,   KEY_ID, 0, 0, 0, 0, 0, 1, ST_EMPTY),
      mk(MODE_FIND,   KEY_ID, 5, 0, 0, 0, 0, 1, ST_EMPTY),
      mk(MODE_UPDATE, KEY_ID, 5, 0, 0, 0, 0, 1, ST_EMPTY),
      mk(MODE_APPEND, KEY_ID, 32'h7fffffff, 8'hff, 32'hffffffff, 16'hffff, 24'hffffff),
      mk(MODE_APPEND, KEY_ID, 32'h80000000, 8'h00, 32'h0, 16'h0, 24'h0),
      mk(MODE_APPEND, KEY_ID, 0, 3, 1999, 7, 40),
      mk(MODE_APPEND, KEY_ID, 0, 1, 250, 7, 40),
      mk(MODE_APPEND, KEY_ID, -7, 5, 250, 2, 9),
      mk(MODE_APPEND, KEY_ID, 1000, 2, 99, 12, 500),
      mk(MODE_DUMP, KEY_CATEGORY, 0, 0, 0, 0, 0),
      mk(MODE_DUMP, KEY_PRICE, 0, 0, 0, 0, 0),
      mk(MODE_DUMP, KEY_SHELF, 0, 0, 0, 0, 0),
      mk(MODE_DUMP, KEY_QTY_UP, 0, 0, 0, 0, 0),
      mk(MODE_DUMP, KEY_QTY_DOWN, 0, 0, 0, 0, 0),
      mk(MODE_DUMP, 3'd6, 0, 0, 0, 0, 0),
      mk(MODE_DUMP, 3'd7, 0, 0, 0, 0, 0),
      mk(MODE_DUMP, KEY_ID, 0, 0, 0, 0, 0),
      mk(MODE_FIND, KEY_ID, 1000, 0, 0, 0, 0),
      mk(MODE_FIND, KEY_ID, 32'h7fffffff, 0, 0, 0, 0),
      mk(MODE_FIND, KEY_ID, 1, 0, 0, 0, 0, 1, ST_NOTFOUND),
      mk(MODE_UPDATE, KEY_ID, 32'h80000000, 0, 32'hffffffff, 16'hffff, 24'hffffff),
      mk(MODE_UPDATE, KEY_ID, 2000, 0, 1, 1, 1, 1, ST_NOTFOUND)
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_cmd(directed[i]);
    while (n_rec < DEPTH) begin
      c = mk(MODE_APPEND, 3'($urandom_range(7)), $urandom, 8'($urandom), $urandom,
             16'($urandom), 24'($urandom));
      if ($urandom_range(1)) c.rec.id = $urandom_range(40) - 20;
      send_cmd(c);
    end
    send_cmd(mk(MODE_APPEND, KEY_ID, 1, 1, 1, 1, 1, 1, ST_FULL));
    for (int i = 0; i < N_RAND; i++) begin
      case ((i / 20) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      send_cmd(rand_cmd());
    end
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rtss_pkg.sv
hdl/rtss_cell.sv
hdl/rtss_div.sv
hdl/record_table_sort_and_search_top.sv
dv/record_table_sort_and_search_top_tb.sv
